/* rtl/core/byte_ring_fifo_with_peek_assert.svh */
// assertion macros for the byte ring fifo
// expects clk_i and rst_ni in the scope of use; empty when SYNTH is defined
`ifndef BYTE_RING_FIFO_WITH_PEEK_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_PEEK_ASSERT_SVH

`ifndef SYNTH
`define BRF_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);
`define BRF_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);
`else
`define BRF_ASSERT_NOW(lbl, ant, cons, msg)
`define BRF_ASSERT_NEXT(lbl, ant, cons, msg)
`endif

`endif

/* rtl/core/brf_pkg.sv */
// shared types and constants of the byte ring fifo
// no dependencies
package brf_pkg;

  localparam int CAP_W = 11;
  localparam int CNT_W = 7;
  localparam int CAP_MAX = (1 << CAP_W) - 1;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] read_count;
    logic             consume;
    logic             discard;
  } brf_req_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             has_byte;
    logic             last;
    logic [CNT_W-1:0] amount;
    logic [CAP_W-1:0] fill_level;
    logic [CAP_W-1:0] space_left;
  } brf_rsp_t;

endpackage

/* rtl/core/byte_ring_fifo_with_peek.sv */
// top level of the byte ring fifo with peek
// depends on brf_pkg, brf_store, brf_step and byte_ring_fifo_with_peek_assert.svh

// Ring FIFO of bytes with a programmable capacity (cfg_wdata_i, 1..DEPTH, zero
// acts as one). A write, flush or unknown-type beat gives one result beat.
// A read beat is clipped to MAX_RUN and to the bytes held; it keeps the input
// stalled until its last result is loaded: a byte run steps through the accept,
// then a store read and an output load per byte, a discarded run through the
// accept and one index step per byte, an empty read through the accept alone.
// This stepping comes from the single registered read port of the byte store and
// the one shared index stepper. Output stall can hold a run at its output load.
`include "byte_ring_fifo_with_peek_assert.svh"
module byte_ring_fifo_with_peek
  import brf_pkg::*;
#(
  parameter int DEPTH   = 1024,
  parameter int MAX_RUN = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  brf_req_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output brf_rsp_t         out_data_o
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [CAP_W-1:0] CAP_RST = CAP_W'((DEPTH > CAP_MAX) ? CAP_MAX : DEPTH);
  localparam logic [CNT_W-1:0] RUN_MAX = CNT_W'(MAX_RUN);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SKIP  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CAP_W-1:0] cap_q;
  logic [CAP_W-1:0] cap_eff;
  logic [AW-1:0]    wi_q, wi_d, ri_q, ri_d, idx_q, idx_d;
  logic [CAP_W-1:0] held_q, held_d;
  logic [CNT_W-1:0] n_q, n_d, cnt_q, cnt_d;
  logic             consume_q, consume_d;
  brf_rsp_t         out_q, rsp;
  logic             out_valid_q;
  logic             load_out;

  logic             in_acc, out_free, write_ok, run_last;
  logic [CNT_W-1:0] n_clip, cnt_inc;
  logic [CAP_W-1:0] held_post, post;
  logic [AW-1:0]    step_op, step_wrap, step_adv;
  logic             mem_we, mem_re;
  logic [7:0]       mem_rdata;

  brf_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(step_wrap),
    .wdata_i(in_data_i.data_byte),
    .re_i   (mem_re),
    .raddr_i(idx_q),
    .rdata_o(mem_rdata)
  );

  brf_step #(
    .AW(AW)
  ) u_step (
    .idx_i (step_op),
    .cap_i (cap_eff),
    .wrap_o(step_wrap),
    .adv_o (step_adv)
  );

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CAP_W'(1);
    end else if (32'(cap_q) > DEPTH) begin
      cap_eff = CAP_W'(DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign write_ok   = held_q < cap_eff;
  assign cnt_inc    = cnt_q + CNT_W'(1);
  assign run_last   = (cnt_inc == n_q);
  assign held_post  = consume_q ? (held_q - CAP_W'(n_q)) : held_q;

  always_comb begin
    n_clip = (in_data_i.read_count > RUN_MAX) ? RUN_MAX : in_data_i.read_count;
    if (CAP_W'(n_clip) > held_q) begin
      n_clip = held_q[CNT_W-1:0];
    end
  end

  always_comb begin
    if (state_q != S_IDLE) begin
      step_op = idx_q;
    end else if (in_data_i.req_type == REQ_WRITE) begin
      step_op = wi_q;
    end else begin
      step_op = ri_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    wi_d      = wi_q;
    ri_d      = ri_q;
    idx_d     = idx_q;
    held_d    = held_q;
    n_d       = n_q;
    cnt_d     = cnt_q;
    consume_d = consume_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    load_out  = 1'b0;
    post      = held_q;
    rsp       = '0;
    rsp.last  = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          load_out = 1'b1;
          unique case (in_data_i.req_type)
            REQ_WRITE: begin
              rsp.amount = CNT_W'(write_ok);
              if (write_ok) begin
                mem_we = 1'b1;
                wi_d   = step_adv;
                held_d = held_q + CAP_W'(1);
                post   = held_q + CAP_W'(1);
              end
            end
            REQ_READ: begin
              n_d       = n_clip;
              cnt_d     = '0;
              idx_d     = step_wrap;
              consume_d = in_data_i.consume;
              if (n_clip != '0) begin
                load_out = 1'b0;
                state_d  = in_data_i.discard ? S_SKIP : S_FETCH;
              end
            end
            REQ_FLUSH: begin
              wi_d   = '0;
              ri_d   = '0;
              held_d = '0;
              post   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SKIP: begin
        idx_d = step_adv;
        cnt_d = cnt_inc;
        if (run_last) begin
          load_out   = 1'b1;
          rsp.amount = n_q;
          post       = held_post;
          held_d     = held_post;
          if (consume_q) begin
            ri_d = step_adv;
          end
          state_d = S_IDLE;
        end
      end
      S_FETCH: begin
        mem_re  = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          load_out     = 1'b1;
          rsp.out_byte = mem_rdata;
          rsp.has_byte = 1'b1;
          rsp.last     = run_last;
          rsp.amount   = n_q;
          post         = held_post;
          idx_d        = step_adv;
          cnt_d        = cnt_inc;
          if (run_last) begin
            held_d = held_post;
            if (consume_q) begin
              ri_d = step_adv;
            end
            state_d = S_IDLE;
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp.fill_level = post;
    rsp.space_left = (post >= cap_eff) ? '0 : (cap_eff - post);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RST;
      wi_q        <= '0;
      ri_q        <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wi_q    <= wi_d;
      ri_q    <= ri_d;
      held_q  <= held_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    n_q       <= n_d;
    cnt_q     <= cnt_d;
    consume_q <= consume_d;
    if (load_out) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BRF_ASSERT_NEXT(a_write_fills, in_acc && (in_data_i.req_type == REQ_WRITE) && write_ok, held_q == $past(held_q) + CAP_W'(1), "stored write did not raise the fill level")
  `BRF_ASSERT_NOW(a_run_bound, (state_q == S_SKIP) || (state_q == S_EMIT), cnt_q < n_q, "read run counter ran past its length")
  `BRF_ASSERT_NEXT(a_empty_read, in_acc && (in_data_i.req_type == REQ_READ) && (in_data_i.read_count == '0), out_valid_o && out_data_o.last && !out_data_o.has_byte, "empty read gave no single final beat")

endmodule

/* rtl/core/brf_store.sv */
// byte store of the ring fifo: one write port, one registered read port
// depends on nothing
module brf_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/brf_step.sv */
// shared ring index stepper: wrap at capacity before access, then advance
// depends on brf_pkg
module brf_step
  import brf_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic [AW-1:0]    idx_i,
  input  logic [CAP_W-1:0] cap_i,
  output logic [AW-1:0]    wrap_o,
  output logic [AW-1:0]    adv_o
);

  localparam int CMP_W = (AW + 1 > CAP_W) ? AW + 1 : CAP_W;

  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] inc;

  always_comb begin
    idx_ext = CMP_W'(idx_i);
    cap_ext = CMP_W'(cap_i);
    wrap_o  = (idx_ext >= cap_ext) ? '0 : idx_i;
    inc     = CMP_W'(wrap_o) + CMP_W'(1);
    adv_o   = (inc >= cap_ext) ? '0 : inc[AW-1:0];
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// testbench for byte_ring_fifo_with_peek: directed and random request streams checked
// beat by beat against a ring model held in this file; depends on brf_pkg and the rtl
module testbench;
  import brf_pkg::*;

  localparam int RING_DEPTH = 1024;
  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int RUN_MAX = 64;
  localparam int RUN_AW = $clog2(RUN_MAX);
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int IDLE_PCT = 9;
  localparam int PRINT_MAX = 40;
  localparam int PHASES = 7;
  localparam int PHASE_W = $clog2(PHASES);
  localparam int REQ_W = $bits(brf_req_t);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  brf_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  brf_rsp_t out_data;

  bit quiet = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned requests_sent = 0;
  int unsigned writes_stored = 0;
  int unsigned writes_refused = 0;
  int unsigned read_runs = 0;
  int unsigned flushes = 0;
  int unsigned unknown_reqs = 0;
  int unsigned results_checked = 0;
  int unsigned cap_settings = 0;
  int unsigned peak_fill = 0;

  // ring model
  logic [7:0] ring_mem [RING_DEPTH];
  bit ring_written [RING_DEPTH];
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;
  int unsigned held = 0;
  logic [CAP_W-1:0] cap_reg = CAP_W'(RING_DEPTH);
  brf_rsp_t expected_rsp_q [$];

  byte_ring_fifo_with_peek #(
    .DEPTH  (RING_DEPTH),
    .MAX_RUN(RUN_MAX)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned eff_cap();
    int unsigned c;
    c = 32'(cap_reg);
    if (c == 0) c = 1;
    if (c > RING_DEPTH) c = RING_DEPTH;
    return c;
  endfunction

  function automatic int unsigned run_length(logic [CNT_W-1:0] count);
    int unsigned n;
    n = 32'(count);
    if (n > RUN_MAX) n = RUN_MAX;
    if (n > held) n = held;
    return n;
  endfunction

  // bytes a read can return before it would touch a slot never written
  function automatic int unsigned safe_run(logic [CNT_W-1:0] count);
    int unsigned c;
    int unsigned n;
    int unsigned idx;
    c = eff_cap();
    n = run_length(count);
    idx = rd_ptr;
    for (int i = 0; i < n; i++) begin
      if (idx >= c) idx = 0;
      if (!ring_written[RING_AW'(idx)]) return i;
      idx = (idx + 1 >= c) ? 0 : idx + 1;
    end
    return n;
  endfunction

  function automatic void push_rsp(logic [7:0] b, logic has, logic last, int unsigned amount);
    brf_rsp_t rsp;
    int unsigned c;
    c = eff_cap();
    rsp.out_byte = b;
    rsp.has_byte = has;
    rsp.last = last;
    rsp.amount = CNT_W'(amount);
    rsp.fill_level = CAP_W'(held);
    rsp.space_left = (held >= c) ? '0 : CAP_W'(c - held);
    expected_rsp_q.push_back(rsp);
  endfunction

  function automatic void apply_request(brf_req_t r);
    int unsigned c;
    int unsigned n;
    int unsigned idx;
    logic [7:0] run_bytes [RUN_MAX];
    c = eff_cap();
    case (r.req_type)
      REQ_WRITE: begin
        if (held < c) begin
          if (wr_ptr >= c) wr_ptr = 0;
          ring_mem[RING_AW'(wr_ptr)] = r.data_byte;
          ring_written[RING_AW'(wr_ptr)] = 1'b1;
          wr_ptr = (wr_ptr + 1 >= c) ? 0 : wr_ptr + 1;
          held++;
          writes_stored++;
          push_rsp(8'h00, 1'b0, 1'b1, 1);
        end else begin
          writes_refused++;
          push_rsp(8'h00, 1'b0, 1'b1, 0);
        end
      end
      REQ_READ: begin
        n = run_length(r.read_count);
        idx = rd_ptr;
        for (int i = 0; i < n; i++) begin
          if (idx >= c) idx = 0;
          run_bytes[RUN_AW'(i)] = ring_mem[RING_AW'(idx)];
          idx = (idx + 1 >= c) ? 0 : idx + 1;
        end
        if (r.consume) begin
          rd_ptr = idx;
          held -= n;
        end
        read_runs++;
        if (r.discard || n == 0) begin
          push_rsp(8'h00, 1'b0, 1'b1, n);
        end else begin
          for (int i = 0; i < n; i++)
            push_rsp(run_bytes[RUN_AW'(i)], 1'b1, i + 1 == n, n);
        end
      end
      REQ_FLUSH: begin
        wr_ptr = 0;
        rd_ptr = 0;
        held = 0;
        flushes++;
        push_rsp(8'h00, 1'b0, 1'b1, 0);
      end
      default: begin
        unknown_reqs++;
        push_rsp(8'h00, 1'b0, 1'b1, 0);
      end
    endcase
    if (held > peak_fill) peak_fill = held;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_MAX) $display("ERROR %0t: %s", $time, msg);
  endtask

  task automatic check_field(string field, logic [CAP_W-1:0] got, logic [CAP_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                results_checked, field, got, want));
  endtask

  task automatic check_result(brf_rsp_t got);
    brf_rsp_t want;
    results_checked++;
    if (expected_rsp_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with none expected", results_checked));
      return;
    end
    want = expected_rsp_q.pop_front();
    check_field("out_byte", CAP_W'(got.out_byte), CAP_W'(want.out_byte));
    check_field("has_byte", CAP_W'(got.has_byte), CAP_W'(want.has_byte));
    check_field("last", CAP_W'(got.last), CAP_W'(want.last));
    check_field("amount", CAP_W'(got.amount), CAP_W'(want.amount));
    check_field("fill_level", got.fill_level, want.fill_level);
    check_field("space_left", got.space_left, want.space_left);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) check_result(out_data);
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // one request beat; valid stays high on return so back-to-back beats need no gap
  task automatic send_req(brf_req_t r);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk_i); while (in_stall);
    requests_sent++;
    apply_request(r);
  endtask

  task automatic send_write(logic [7:0] data);
    brf_req_t r;
    r = REQ_W'($urandom);
    r.req_type = REQ_WRITE;
    r.data_byte = data;
    send_req(r);
  endtask

  task automatic send_read(logic [CNT_W-1:0] count, logic consume, logic discard);
    brf_req_t r;
    int unsigned n;
    int unsigned s;
    r = REQ_W'($urandom);
    r.req_type = REQ_READ;
    r.consume = consume;
    r.discard = discard;
    n = run_length(count);
    s = safe_run(count);
    r.read_count = (s < n) ? CNT_W'(s) : count;
    send_req(r);
  endtask

  task automatic send_other(logic [1:0] kind);
    brf_req_t r;
    r = REQ_W'($urandom);
    r.req_type = kind;
    send_req(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_rsp_q.size() != 0);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cap_reg = value;
    cap_settings++;
  endtask

  task automatic test_basic_requests();
    send_write(8'h00);
    send_write(8'hFF);
    send_write(8'hA5);
    send_write(8'h5A);
    send_write(8'h3C);
    send_read(7'd2, 1'b0, 1'b0);
    send_read(7'd3, 1'b0, 1'b1);
    send_read(7'd1, 1'b1, 1'b1);
    send_read(7'd0, 1'b1, 1'b0);
    send_read(7'd127, 1'b1, 1'b0);
    send_write(8'h96);
    send_other(REQ_UNKNOWN);
    send_other(REQ_FLUSH);
    send_read(7'd64, 1'b1, 1'b0);
  endtask

  task automatic test_capacity_limits();
    // zero capacity acts as a single slot
    set_capacity('0);
    send_write(8'h11);
    send_write(8'h22);
    send_read(7'd1, 1'b1, 1'b0);
    set_capacity(CAP_W'(8));
    for (int i = 0; i < 5; i++) send_write(8'(8'h40 + i));
    // shrink below the fill: held over capacity, indices wrap to slot 0
    set_capacity(CAP_W'(3));
    send_write(8'hEE);
    send_read(7'd4, 1'b1, 1'b0);
    send_write(8'h77);
    send_read(7'd127, 1'b1, 1'b0);
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [PHASES];
    int unsigned quota [PHASES];
    int unsigned done;
    int unsigned burst;
    int unsigned pick;
    logic [CNT_W-1:0] count;
    caps = '{CAP_W'(CAP_MAX), CAP_W'(RING_DEPTH), CAP_W'(64), CAP_W'(2), CAP_W'(1),
             CAP_W'($urandom_range(3, RING_DEPTH - 1)), CAP_W'(100)};
    quota = '{110, 80, 70, 50, 40, 80, 70};
    for (int p = 0; p < PHASES; p++) begin
      set_capacity(caps[PHASE_W'(p)]);
      quiet = (p == 2);
      done = 0;
      while (done < quota[PHASE_W'(p)]) begin
        // a write burst, then a few reads of random shape
        burst = ($urandom_range(5) == 0) ? $urandom_range(65, 90) : $urandom_range(1, 24);
        if (burst > quota[PHASE_W'(p)] - done) burst = quota[PHASE_W'(p)] - done;
        repeat (burst) send_write(8'($urandom));
        done += burst;
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(3))
            0: count = CNT_W'($urandom_range(0, 127));
            1: count = CNT_W'($urandom_range(1, 16));
            2: count = CNT_W'($urandom_range(1, 64));
            default: count = CNT_W'($urandom_range(64, 127));
          endcase
          send_read(count, $urandom_range(3) != 0, $urandom_range(4) == 0);
          done++;
        end
        pick = $urandom_range(99);
        if (pick < 8) begin
          send_other(REQ_FLUSH);
          done++;
        end else if (pick < 14) begin
          send_other(REQ_UNKNOWN);
        end else if (pick < 20) begin
          wait_drained();
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_requests();
    test_capacity_limits();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("covered %0d requests: %0d bytes stored, %0d writes refused, %0d read runs,",
             requests_sent, writes_stored, writes_refused, read_runs);
    $display("%0d flushes, %0d unknown types; %0d result beats over %0d capacities, peak fill %0d",
             flushes, unknown_reqs, results_checked, cap_settings, peak_fill);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
